// ----- design/pfa_pkg.sv -----
// pfa_pkg: shared types and constants for the partition fit allocator.
// No dependencies.
package pfa_pkg;
  localparam int NumPartsDef = 16;
  localparam int SizeBitsDef = 20;
  localparam int AddrW = 20;
  localparam int OwnerW = 8;
  localparam int IdxW = 4;
  localparam int FillW = 24;
  localparam logic [FillW-1:0] FillMax = '1;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_NEXT  = 2'd1,
    MODE_BEST  = 2'd2,
    MODE_WORST = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOOWNER  = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_OUT  = 2'd2
  } fsm_e;

  // token walking the cell chain
  typedef struct packed {
    logic              found;
    logic [7:0]        pidx;
    logic [31:0]       psize;
  } tok_t;
endpackage

// ----- design/pfa_cell.sv -----
// pfa_cell: one partition slot; evaluates the search token passing by.
// Depends on pfa_pkg.
module pfa_cell #(
  parameter int SizeBits = pfa_pkg::SizeBitsDef,
  parameter int CellIdx  = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic                      hole_i,
  input  logic [SizeBits-1:0]       size_i,
  input  logic [pfa_pkg::AddrW-1:0] base_i,
  input  logic [pfa_pkg::OwnerW-1:0] owner_i,
  input  logic                      grant_i,
  input  logic                      release_i,
  input  logic [1:0]                func_i,
  input  logic [1:0]                mode_i,
  input  logic [SizeBits-1:0]       req_i,
  input  logic                      elig_i,
  input  pfa_pkg::tok_t             tok_i,
  output pfa_pkg::tok_t             tok_o,
  output logic [pfa_pkg::AddrW-1:0] base_o
);
  import pfa_pkg::*;
  logic valid_q, free_q;
  logic [SizeBits-1:0] size_q;
  logic [AddrW-1:0] base_q;
  logic [OwnerW-1:0] owner_q;
  logic hit, take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (load_i) valid_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      free_q <= hole_i; size_q <= size_i; base_q <= base_i; owner_q <= owner_i;
    end else if (grant_i) begin
      free_q <= 1'b0; owner_q <= owner_i;
    end else if (release_i) begin
      free_q <= 1'b1;
    end
  end

  always_comb begin
    if (func_i == FUNC_FREE) hit = valid_q && !free_q && owner_q == owner_i;
    else hit = valid_q && free_q && size_q >= req_i;
    hit = hit && elig_i;
    take = 1'b0;
    if (hit) begin
      if (!tok_i.found) take = 1'b1;
      else if (func_i == FUNC_ALLOC && mode_i == MODE_BEST)
        take = 32'(size_q) < tok_i.psize;
      else if (func_i == FUNC_ALLOC && mode_i == MODE_WORST)
        take = 32'(size_q) > tok_i.psize;
    end
    tok_o = tok_i;
    if (take) begin
      tok_o.found = 1'b1;
      tok_o.pidx = 8'(CellIdx);
      tok_o.psize = 32'(size_q);
    end
  end
  assign base_o = base_q;
endmodule

// ----- design/partition_fit_allocator_unit.sv -----
// Top level of the partition fit allocator: control sequencer plus a chain of slot cells.
// Depends on pfa_pkg and pfa_cell.
// Timing: a load or unused code has its result valid in the cycle after acceptance; allocate
// and free step the token through every slot cell in S_SCAN, then S_OUT writes the result register.
// One request at a time: a new request is taken only in S_IDLE with the output register free,
// so an allocate or free must finish its scan and S_OUT before the next request is taken.
// Reset (rst_ni low, async): slot table empty, rover 0, filled total 0, fit mode first fit.
module partition_fit_allocator_unit #(
  parameter int NUM_PARTS = pfa_pkg::NumPartsDef,
  parameter int SIZE_BITS = pfa_pkg::SizeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: func[1:0], entry_index[5:2], size_value[25:6], base_addr[45:26],
  //        owner_id[53:46], is_free[54], zero pad [55]
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: status[1:0], part_index[5:2], granted_base[25:6], total_filled[49:26],
  //        zero pad [55:50]
  output logic [55:0] m_axis_tdata_o
);
  import pfa_pkg::*;
  localparam int PW = $clog2(NUM_PARTS);
  localparam int CW = $clog2(NUM_PARTS + 1);

  logic [1:0] mode_q;
  fsm_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] rover_q;
  logic [FillW-1:0] fill_q;
  logic [1:0] func_q;
  logic [SIZE_BITS-1:0] req_q;
  logic [OwnerW-1:0] own_q;
  tok_t tok_q;
  logic [55:0] out_q;
  logic outv_q;

  // input fields
  logic [1:0] in_func;
  logic [IdxW-1:0] in_idx;
  logic [19:0] in_size;
  logic [AddrW-1:0] in_base;
  logic [OwnerW-1:0] in_own;
  logic in_hole;
  assign in_func = s_axis_tdata_i[1:0];
  assign in_idx  = s_axis_tdata_i[5:2];
  assign in_size = s_axis_tdata_i[25:6];
  assign in_base = s_axis_tdata_i[45:26];
  assign in_own  = s_axis_tdata_i[53:46];
  assign in_hole = s_axis_tdata_i[54];

  logic acc;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;
  // the sequencer takes a new request only when idle and the output register is free
  assign s_axis_tready_o = (state_q == S_IDLE) && (!outv_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= MODE_FIRST;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  // token chain: the token sits in tok_q and visits one cell per cycle.
  // Cell at position cnt_q sees it; for next-fit allocation cells are visited from rover.
  logic [PW-1:0] cur;
  logic [PW:0] rov_sum;
  tok_t tok_arr [NUM_PARTS];
  logic [AddrW-1:0] base_arr [NUM_PARTS];
  logic scanning;
  assign scanning = state_q == S_SCAN;
  assign rov_sum = {1'b0, rover_q} + (PW+1)'(cnt_q);
  always_comb begin
    if (func_q == FUNC_ALLOC && mode_q == MODE_NEXT) begin
      // wrap once around the table
      if (rov_sum >= (PW+1)'(NUM_PARTS)) cur = PW'(rov_sum - (PW+1)'(NUM_PARTS));
      else cur = PW'(rov_sum);
    end else cur = PW'(cnt_q);
  end

  logic fin_ok;
  logic [PW-1:0] fin_idx;
  assign fin_ok  = tok_q.found;
  assign fin_idx = PW'(tok_q.pidx);
  logic do_grant, do_rel;
  assign do_grant = (state_q == S_OUT) && fin_ok && func_q == FUNC_ALLOC;
  assign do_rel   = (state_q == S_OUT) && fin_ok && func_q == FUNC_FREE;

  logic idx_ok;
  assign idx_ok = 32'(in_idx) < NUM_PARTS;

  for (genvar g = 0; g < NUM_PARTS; g++) begin : g_cell
    pfa_cell #(.SizeBits(SIZE_BITS), .CellIdx(g)) u_cell (
      .clk_i, .rst_ni,
      .load_i   (acc && in_func == FUNC_LOAD && idx_ok && PW'(in_idx) == PW'(g)),
      .hole_i   (in_hole),
      .size_i   (SIZE_BITS'(in_size)),
      .base_i   (in_base),
      // live owner only for a load; scan and grant use the captured owner
      .owner_i  ((state_q == S_IDLE) ? in_own : own_q),
      .grant_i  (do_grant && fin_idx == PW'(g)),
      .release_i(do_rel && fin_idx == PW'(g)),
      .func_i   (func_q),
      .mode_i   (mode_q),
      .req_i    (req_q),
      .elig_i   (scanning && cur == PW'(g)),
      .tok_i    (tok_q),
      .tok_o    (tok_arr[g]),
      .base_o   (base_arr[g])
    );
  end

  // the visited cell's token output is the next token
  tok_t tok_next;
  always_comb begin
    tok_next = tok_q;
    if (scanning) tok_next = tok_arr[cur];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; rover_q <= '0; fill_q <= '0; outv_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
      if (do_grant) begin
        rover_q <= (32'(fin_idx) == NUM_PARTS - 1) ? '0 : fin_idx + 1'b1;
        fill_q <= ({1'b0, fill_q} + 25'(req_q) > {1'b0, FillMax}) ? FillMax
                  : fill_q + 24'(req_q);
      end
      if (m_axis_tready_i) outv_q <= 1'b0;
      if ((acc && (in_func == FUNC_LOAD || in_func == FUNC_NONE)) || state_q == S_OUT)
        outv_q <= 1'b1;
    end
  end

  logic [FillW-1:0] fill_new;
  assign fill_new = ({1'b0, fill_q} + 25'(req_q) > {1'b0, FillMax}) ? FillMax
                    : fill_q + 24'(req_q);

  always_ff @(posedge clk_i) begin
    if (acc) begin
      func_q <= in_func; req_q <= SIZE_BITS'(in_size); own_q <= in_own;
      tok_q <= '0;
      if (in_func == FUNC_LOAD)
        out_q <= {6'd0, fill_q, idx_ok ? in_base : 20'd0, in_idx,
                  idx_ok ? ST_DONE : ST_NOFIT};
      else if (in_func == FUNC_NONE)
        out_q <= {6'd0, fill_q, 20'd0, 4'd0, ST_DONE};
    end else if (scanning) begin
      tok_q <= tok_next;
    end else if (state_q == S_OUT) begin
      if (fin_ok)
        out_q <= {6'd0, (func_q == FUNC_ALLOC) ? fill_new : fill_q, base_arr[fin_idx],
                  IdxW'(fin_idx), ST_DONE};
      else
        out_q <= {6'd0, fill_q, 20'd0, 4'd0,
                  (func_q == FUNC_ALLOC) ? ST_NOFIT : ST_NOOWNER};
    end
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q;
    unique case (state_q)
      S_IDLE: if (acc && (in_func == FUNC_ALLOC || in_func == FUNC_FREE)) begin
        state_d = S_SCAN; cnt_d = '0;
      end
      S_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == NUM_PARTS - 1) state_d = S_OUT;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = outv_q;
  assign m_axis_tdata_o = out_q;

  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !s_axis_tready_o) else $error("accept while busy");
  a_cnt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> 32'(cnt_q) < NUM_PARTS) else $error("scan count overrun");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |=> m_axis_tvalid_o) else $error("result lost");
endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for partition_fit_allocator_unit: a predictor checks every result of loads,
// allocations, frees and unused codes in all four fit modes, with random idling on both sides.
// Depends on pfa_pkg and the RTL of partition_fit_allocator_unit.
`timescale 1ns / 100ps

module testbench;
  import pfa_pkg::*;

  localparam int Parts = 16;
  localparam int LatencyWait = 24;   // covers the scan of every slot cell and S_OUT, with margin
  localparam int CycleLimit = 1000000;

  typedef struct {
    func_e       func;
    logic [3:0]  idx;
    logic [19:0] size;
    logic [19:0] base;
    logic [7:0]  owner;
    logic        hole;
  } alloc_req_t;

  typedef struct {
    status_e     status;
    logic [3:0]  pidx;
    logic [19:0] gbase;
    logic [23:0] filled;
  } alloc_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [55:0] req_data = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [55:0] rsp_data;

  // idling controls, set per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold_cycles = 0;
  bit          failed = 1'b0;
  int unsigned cycle_cnt = 0;

  // shadow of the partition table
  logic        tbl_valid [Parts];
  logic        tbl_free  [Parts];
  logic [19:0] tbl_size  [Parts];
  logic [19:0] tbl_base  [Parts];
  logic [7:0]  tbl_owner [Parts];
  logic [3:0]  tbl_rover = '0;
  logic [23:0] tbl_filled = '0;
  mode_e       tbl_mode = MODE_FIRST;

  alloc_rsp_t  expected_rsp_q [$];

  always #4 clk = ~clk;

  partition_fit_allocator_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (req_ready),
    .s_axis_tdata_i  (req_data),
    .m_axis_tvalid_o (rsp_valid),
    .m_axis_tready_i (rsp_ready),
    .m_axis_tdata_o  (rsp_data)
  );

  function automatic logic slot_fits(int i, logic [19:0] want);
    return tbl_valid[i] && tbl_free[i] && (tbl_size[i] >= want);
  endfunction

  // Pick the slot for an allocation under the current fit mode; -1 if none fits.
  function automatic int pick_slot(logic [19:0] want);
    int pick;
    int j;
    pick = -1;
    if (tbl_mode == MODE_NEXT) begin
      for (int i = 0; i < Parts; i++) begin
        j = (int'(tbl_rover) + i) % Parts;
        if (slot_fits(j, want)) return j;
      end
      return -1;
    end
    for (int i = 0; i < Parts; i++) begin
      if (!slot_fits(i, want)) continue;
      if (pick < 0) begin
        pick = i;
        if (tbl_mode == MODE_FIRST) return pick;
      end else if (tbl_mode == MODE_BEST && tbl_size[i] < tbl_size[pick]) begin
        pick = i;
      end else if (tbl_mode == MODE_WORST && tbl_size[i] > tbl_size[pick]) begin
        pick = i;
      end
    end
    return pick;
  endfunction

  // Apply one request to the shadow table and return the result it must produce.
  function automatic alloc_rsp_t apply_request(alloc_req_t r);
    alloc_rsp_t o;
    int k;
    logic [24:0] sum;
    o = '{ST_DONE, 4'd0, 20'd0, 24'd0};
    case (r.func)
      FUNC_LOAD: begin
        o.pidx = r.idx;
        tbl_valid[r.idx] = 1'b1;
        tbl_free[r.idx]  = r.hole;
        tbl_size[r.idx]  = r.size;
        tbl_base[r.idx]  = r.base;
        tbl_owner[r.idx] = r.owner;
        o.gbase = r.base;
      end
      FUNC_ALLOC: begin
        k = pick_slot(r.size);
        if (k < 0) begin
          o.status = ST_NOFIT;
        end else begin
          sum = {1'b0, tbl_filled} + 25'(r.size);
          tbl_free[k] = 1'b0;
          tbl_owner[k] = r.owner;
          tbl_filled = sum[24] ? FillMax : sum[23:0];
          tbl_rover = 4'(k + 1);
          o.pidx = 4'(k);
          o.gbase = tbl_base[k];
        end
      end
      FUNC_FREE: begin
        o.status = ST_NOOWNER;
        for (int i = 0; i < Parts; i++) begin
          if (tbl_valid[i] && !tbl_free[i] && tbl_owner[i] == r.owner) begin
            tbl_free[i] = 1'b1;
            o.status = ST_DONE;
            o.pidx = 4'(i);
            o.gbase = tbl_base[i];
            break;
          end
        end
      end
      default: ;
    endcase
    o.filled = tbl_filled;
    return o;
  endfunction

  function automatic alloc_req_t unpack_req(logic [55:0] d);
    alloc_req_t r;
    r.func  = func_e'(d[1:0]);
    r.idx   = d[5:2];
    r.size  = d[25:6];
    r.base  = d[45:26];
    r.owner = d[53:46];
    r.hole  = d[54];
    return r;
  endfunction

  // Result side: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predict on each accepted request, compare each accepted result.
  always @(posedge clk) begin
    alloc_rsp_t exp_rsp;
    if (rst_n) begin
      if (req_valid && req_ready) expected_rsp_q.push_back(apply_request(unpack_req(req_data)));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request pending: %h", rsp_data);
          failed = 1'b1;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_data[1:0] !== exp_rsp.status) begin
            $error("status exp %0d got %0d", exp_rsp.status, rsp_data[1:0]);
            failed = 1'b1;
          end
          if (rsp_data[5:2] !== exp_rsp.pidx) begin
            $error("part_index exp %0d got %0d", exp_rsp.pidx, rsp_data[5:2]);
            failed = 1'b1;
          end
          if (rsp_data[25:6] !== exp_rsp.gbase) begin
            $error("granted_base exp %h got %h", exp_rsp.gbase, rsp_data[25:6]);
            failed = 1'b1;
          end
          if (rsp_data[49:26] !== exp_rsp.filled) begin
            $error("total_filled exp %h got %h", exp_rsp.filled, rsp_data[49:26]);
            failed = 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("partition_fit_allocator_unit test failed");
      $finish;
    end
  end

  // Offer one request, after a random idle gap; valid stays high into the next request.
  task automatic send_request(func_e f, logic [3:0] idx, logic [19:0] size,
                              logic [19:0] base, logic [7:0] owner, logic hole);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= {1'b0, hole, owner, base, size, idx, f};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every result is back and the block is quiet.
  task automatic drain;
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp_q.size() > 0) @(posedge clk);
    repeat (LatencyWait) @(posedge clk);
  endtask

  task automatic set_mode(mode_e m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_mode = m;
  endtask

  function automatic logic [19:0] pick_size();
    return ($urandom_range(9) < 8) ? 20'($urandom_range(4096)) : 20'($urandom);
  endfunction

  function automatic logic [7:0] pick_owner();
    return ($urandom_range(9) < 8) ? 8'($urandom_range(7)) : 8'($urandom);
  endfunction

  // One random request, mostly allocate/free against a table kept populated.
  task automatic send_random;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15)
      send_request(FUNC_LOAD, 4'($urandom), pick_size(), 20'($urandom), pick_owner(),
                   ($urandom_range(3) != 0));
    else if (r < 55)
      send_request(FUNC_ALLOC, 4'($urandom), pick_size(), 20'($urandom), pick_owner(),
                   1'($urandom));
    else if (r < 92)
      send_request(FUNC_FREE, 4'($urandom), 20'($urandom), 20'($urandom), pick_owner(),
                   1'($urandom));
    else
      send_request(FUNC_NONE, 4'($urandom), 20'($urandom), 20'($urandom), 8'($urandom),
                   1'($urandom));
  endtask

  // Edge values: empty table, size and address extremes, misses, unused code.
  task automatic test_directed;
    send_request(FUNC_ALLOC, 4'd0, 20'd0, 20'd0, 8'd1, 1'b0);        // empty table
    send_request(FUNC_FREE, 4'd0, 20'd0, 20'd0, 8'd1, 1'b0);         // no owner
    send_request(FUNC_NONE, 4'hF, 20'hFFFFF, 20'hFFFFF, 8'hFF, 1'b1);
    send_request(FUNC_LOAD, 4'd0, 20'd0, 20'h00000, 8'd0, 1'b1);
    send_request(FUNC_LOAD, 4'd15, 20'hFFFFF, 20'hFFFFF, 8'hFF, 1'b1);
    send_request(FUNC_LOAD, 4'd7, 20'd100, 20'h12345, 8'h55, 1'b0);  // owned entry
    send_request(FUNC_LOAD, 4'd3, 20'd100, 20'hAAAAA, 8'h2, 1'b1);
    send_request(FUNC_ALLOC, 4'd0, 20'd0, 20'd0, 8'hFF, 1'b0);       // size zero
    send_request(FUNC_ALLOC, 4'd0, 20'hFFFFF, 20'd0, 8'h80, 1'b0);   // largest
    send_request(FUNC_ALLOC, 4'd0, 20'hFFFFF, 20'd0, 8'h81, 1'b0);   // nothing left
    send_request(FUNC_ALLOC, 4'd0, 20'd50, 20'd0, 8'h55, 1'b0);
    send_request(FUNC_FREE, 4'd0, 20'd0, 20'd0, 8'h55, 1'b0);        // lowest owned slot
    send_request(FUNC_FREE, 4'd0, 20'd0, 20'd0, 8'h55, 1'b0);
    send_request(FUNC_FREE, 4'd0, 20'd0, 20'd0, 8'h80, 1'b0);
    send_request(FUNC_FREE, 4'd0, 20'd0, 20'd0, 8'h80, 1'b0);        // already freed
    drain();
  endtask

  // Ties and ordering per mode: holes of three sizes, 512, 1024 and 1536, each repeated.
  task automatic test_mode(mode_e m, int n_items);
    set_mode(m);
    for (int i = 0; i < Parts; i++)
      send_request(FUNC_LOAD, 4'(i), 20'(512 * (1 + (i % 3))), 20'($urandom), 8'd0, 1'b1);
    for (int i = 0; i < n_items; i++) send_random();
    drain();
  endtask

  // Hold off the result side long enough that the block backs up its input.
  task automatic test_backpressure;
    recv_hold_cycles = 400;
    send_idle_pct = 0;
    for (int i = 0; i < 40; i++) send_random();
    drain();
  endtask

  // Filled total saturates: repeated largest grants and frees of one huge hole.
  task automatic test_saturation;
    send_request(FUNC_LOAD, 4'd9, 20'hFFFFF, 20'h0F0F0, 8'd0, 1'b1);
    for (int i = 0; i < 20; i++) begin
      send_request(FUNC_ALLOC, 4'd0, 20'hFFFFF, 20'd0, 8'hEE, 1'b0);
      send_request(FUNC_FREE, 4'd0, 20'd0, 20'd0, 8'hEE, 1'b0);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < Parts; i++) tbl_valid[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      test_mode(mode_e'(p % 4), 150);
      if (p == 3) test_backpressure();
    end
    send_idle_pct = 15;
    recv_stall_pct = 15;
    test_saturation();
    set_mode(MODE_WORST);
    test_saturation();

    if (!failed)
      $display("partition_fit_allocator_unit test passed");
    else
      $display("partition_fit_allocator_unit test failed");
    $finish;
  end

endmodule
